@@ hw/rtl/binary_max_heap_core_defines.svh @@
// Assertion macros shared by the heap core checker.
// Needs a clk and an rst_n in scope at the point of use.
`ifndef BINARY_MAX_HEAP_CORE_DEFINES_SVH
`define BINARY_MAX_HEAP_CORE_DEFINES_SVH

// Checked only outside reset
`define BMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define BMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/bmh_pkg.sv @@
// Shared types and constants for the binary max-heap core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bmh_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned VALUE_W      = 31;
  localparam int unsigned STS_W        = 2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_UP_RD,
    CMD_UP_STEP,
    CMD_POP_LD,
    CMD_DN_RD,
    CMD_DN_STEP,
    CMD_PLACE,
    CMD_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } bmh_cmd_t;

  // datapath conditions seen by the controller
  typedef struct packed {
    logic is_empty;       // no stored values
    logic is_full;        // store at capacity
    logic at_root;        // sift-up position is the root
    logic parent_less;    // parent read back is below the moving value
    logic at_leaf;        // sift-down position has no child
    logic child_greater;  // larger child is above the moving value
  } bmh_sts_t;

endpackage

@@ hw/rtl/bmh_datapath.sv @@
// Heap store, element count, sift position and result registers.
// Depends on bmh_pkg; driven by bmh_ctrl through bmh_cmd_t.
`timescale 1ns / 1ps

module bmh_datapath #(
  parameter int unsigned CAPACITY = bmh_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmh_pkg::bmh_cmd_t             cmd,
  input  logic                          in_op,
  input  logic [bmh_pkg::VALUE_W-1:0]   in_value,
  output bmh_pkg::bmh_sts_t             sts,
  output logic [bmh_pkg::VALUE_W-1:0]   out_value,
  output logic [bmh_pkg::STS_W-1:0]     out_status
);
  import bmh_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  logic [VALUE_W-1:0] mem [CAPACITY];

  logic [PW-1:0]      count_r, count_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [VALUE_W-1:0] x_r, x_nxt;
  logic [VALUE_W-1:0] res_val_r, res_val_nxt;
  logic [STS_W-1:0]   res_sts_r, res_sts_nxt;
  logic [VALUE_W-1:0] out_val_r;
  logic [STS_W-1:0]   out_sts_r;
  logic [VALUE_W-1:0] rd_a_r, rd_b_r;

  logic [PW:0]        pos2, pos2p1, pos2m1, cnt_x;
  logic [PW-1:0]      pos_m1, par_m1, cnt_m1, child_pos;
  logic               pick_right;
  logic [VALUE_W-1:0] child_val, wr_data;
  logic [AW-1:0]      rd_a_addr, rd_b_addr, wr_addr;
  logic               wr_en;

  // child positions and larger-child pick (right child on a tie)
  assign pos2       = {pos_r, 1'b0};
  assign pos2p1     = {pos_r, 1'b1};
  assign pos2m1     = pos2 - {1'b0, ONE_P};
  assign cnt_x      = {1'b0, count_r};
  assign pick_right = (pos2p1 <= cnt_x) && !(rd_a_r > rd_b_r);
  assign child_val  = pick_right ? rd_b_r : rd_a_r;
  assign child_pos  = pick_right ? pos2p1[PW-1:0] : pos2[PW-1:0];

  assign pos_m1 = pos_r - ONE_P;
  assign par_m1 = (pos_r >> 1) - ONE_P;
  assign cnt_m1 = count_r - ONE_P;

  // conditions for the controller
  always_comb begin
    sts.is_empty      = (count_r == '0);
    sts.is_full       = (count_r == CAP_P);
    sts.at_root       = (pos_r == ONE_P);
    sts.parent_less   = (rd_a_r < x_r);
    sts.at_leaf       = (pos2 > cnt_x);
    sts.child_greater = (x_r < child_val);
  end

  // read address selection; positions are one-based, addresses zero-based
  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    case (cmd.op)
      CMD_ACCEPT: begin
        rd_a_addr = '0;
        rd_b_addr = cnt_m1[AW-1:0];
      end
      CMD_UP_RD: begin
        rd_a_addr = par_m1[AW-1:0];
      end
      CMD_DN_RD: begin
        rd_a_addr = pos2m1[AW-1:0];
        rd_b_addr = pos2[AW-1:0];
      end
      default: begin
        rd_a_addr = '0;
        rd_b_addr = '0;
      end
    endcase
  end

  // write port: move a parent down, a child up, or drop the held value in
  always_comb begin
    wr_en   = 1'b0;
    wr_data = x_r;
    case (cmd.op)
      CMD_UP_STEP: begin
        wr_en   = 1'b1;
        wr_data = rd_a_r;
      end
      CMD_DN_STEP: begin
        wr_en   = 1'b1;
        wr_data = child_val;
      end
      CMD_PLACE: begin
        wr_en   = 1'b1;
        wr_data = x_r;
      end
      default: begin
        wr_en   = 1'b0;
        wr_data = x_r;
      end
    endcase
  end
  assign wr_addr = pos_m1[AW-1:0];

  // heap store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  // next values of count, position, held value and result
  always_comb begin
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    x_nxt       = x_r;
    res_val_nxt = res_val_r;
    res_sts_nxt = res_sts_r;
    case (cmd.op)
      CMD_ACCEPT: begin
        x_nxt       = in_value;
        res_val_nxt = '0;
        if (in_op == OP_PUSH) begin
          res_sts_nxt = sts.is_full ? ST_FULL : ST_OK;
          if (!sts.is_full) begin
            count_nxt = count_r + ONE_P;
            pos_nxt   = count_r + ONE_P;
          end
        end else begin
          res_sts_nxt = sts.is_empty ? ST_EMPTY : ST_OK;
          if (!sts.is_empty) begin
            count_nxt = cnt_m1;
          end
        end
      end
      CMD_UP_STEP: begin
        pos_nxt = pos_r >> 1;
      end
      CMD_POP_LD: begin
        res_val_nxt = rd_a_r;
        x_nxt       = rd_b_r;
        pos_nxt     = ONE_P;
      end
      CMD_DN_STEP: begin
        pos_nxt = child_pos;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    x_r       <= x_nxt;
    res_val_r <= res_val_nxt;
    res_sts_r <= res_sts_nxt;
    if (cmd.op == CMD_EMIT) begin
      out_val_r <= res_val_r;
      out_sts_r <= res_sts_r;
    end
  end

  assign out_value  = out_val_r;
  assign out_status = out_sts_r;

endmodule

@@ hw/rtl/bmh_ctrl.sv @@
// Controller state machine sequencing push and pop sifts.
// Depends on bmh_pkg; steers bmh_datapath through bmh_cmd_t.
`timescale 1ns / 1ps

module bmh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_op,
  input  logic               out_tready,
  input  bmh_pkg::bmh_sts_t  sts,
  output bmh_pkg::bmh_cmd_t  cmd,
  output logic               in_tready,
  output logic               out_tvalid
);
  import bmh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = CMD_ACCEPT;
          if (in_op == OP_PUSH) begin
            state_nxt = sts.is_full ? S_FIN : S_UP_RD;
          end else begin
            state_nxt = sts.is_empty ? S_FIN : S_POP_LD;
          end
        end
      end
      S_UP_RD: begin
        if (sts.at_root) begin
          cmd.op    = CMD_PLACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_UP_RD;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.parent_less) begin
          cmd.op    = CMD_UP_STEP;
          state_nxt = S_UP_RD;
        end else begin
          cmd.op    = CMD_PLACE;
          state_nxt = S_FIN;
        end
      end
      S_POP_LD: begin
        cmd.op    = CMD_POP_LD;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (sts.at_leaf) begin
          cmd.op    = CMD_PLACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_DN_RD;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.child_greater) begin
          cmd.op    = CMD_DN_STEP;
          state_nxt = S_DN_RD;
        end else begin
          cmd.op    = CMD_PLACE;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op    = CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    if (cmd.op == CMD_EMIT) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

@@ hw/rtl/binary_max_heap_core.sv @@
// Channel   Dir  Ports                           Content
// in_       in   tvalid tready tdata[31:0] tuser value, operation
// out_      out  tvalid tready tdata[31:0] tuser max_value, status
//
// Push: accept, climb L levels, place, emit; pop: accept, load, descend L levels, place, emit.
// Each level is one registered store read followed by a compare and one store write.
// A dropped push or an empty pop goes from accept straight to the result.
// Reset (synchronous, rst_n low) empties the heap; store contents are not cleared.
// The result register holds while out_tready is low; a new item is taken meanwhile.
// Top level of the binary max-heap; depends on bmh_pkg, bmh_ctrl, bmh_datapath.
`timescale 1ns / 1ps

module binary_max_heap_core #(
  parameter int unsigned CAPACITY = bmh_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] value, [31] zero fill
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] max_value, [31] zero fill
  output logic [1:0]  out_tuser   // [1:0] status
);
  import bmh_pkg::*;

  bmh_cmd_t           cmd;
  bmh_sts_t           sts;
  logic [VALUE_W-1:0] out_value;
  logic [STS_W-1:0]   out_status;

  bmh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser[0]),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  bmh_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tuser[0]),
    .in_value   (in_tdata[VALUE_W-1:0]),
    .sts        (sts),
    .out_value  (out_value),
    .out_status (out_status)
  );

  assign out_tdata = {1'b0, out_value};
  assign out_tuser = out_status;

endmodule

@@ hw/rtl/bmh_checker.sv @@
// Port-level checks for binary_max_heap_core, attached by bind.
// Depends on bmh_pkg and binary_max_heap_core_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "binary_max_heap_core_defines.svh"

module bmh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import bmh_pkg::*;

  // reset leaves the block ready with no result pending
  `BMH_ASSERT_ALWAYS(a_reset_state, !rst_n |=> in_tready && !out_tvalid, "bad state after reset")

  // one item at a time: ready drops right after an item is taken
  `BMH_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "ready held after accept")

  // failed operations carry a zero value, status is always a defined code with a clear fill bit
  `BMH_ASSERT(a_err_zero, out_tvalid && out_tuser != ST_OK |-> out_tdata == 32'd0, "nonzero value on error")
  `BMH_ASSERT(a_sts_code, out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_EMPTY || out_tuser == ST_FULL) && !out_tdata[31], "bad status or fill bit")

  // a stalled result holds
  `BMH_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

endmodule

bind binary_max_heap_core bmh_checker u_bmh_checker (.*);
